@@ sv/escaped_frame_encoder_core_assert.svh @@
// Assertion macros for the escaped frame encoder
`ifndef ESCAPED_FRAME_ENCODER_CORE_ASSERT_SVH
`define ESCAPED_FRAME_ENCODER_CORE_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define EFE_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("escaped frame encoder assertion failed");

// Check that a condition implies another in the next cycle
`define EFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("escaped frame encoder assertion failed");

`endif

@@ sv/efe_pkg.sv @@
package efe_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CapW  = 16;
  localparam int unsigned KindW = 2;
  localparam int unsigned IdxW  = 3;

  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  localparam int unsigned DefQueueDepth = 4;

  localparam logic [KindW-1:0] KIND_START = 2'd0;
  localparam logic [KindW-1:0] KIND_DATA  = 2'd1;
  localparam logic [KindW-1:0] KIND_END   = 2'd2;

  localparam logic [2:0] REG_START_BYTE = 3'd0;
  localparam logic [2:0] REG_END_BYTE   = 3'd1;
  localparam logic [2:0] REG_ESC_BYTE   = 3'd2;
  localparam logic [2:0] REG_CODE_ESC   = 3'd3;
  localparam logic [2:0] REG_CODE_START = 3'd4;
  localparam logic [2:0] REG_CODE_END   = 3'd5;
  localparam logic [2:0] REG_FLAGS      = 3'd6;
  localparam logic [2:0] REG_CAPACITY   = 3'd7;

  localparam logic [IdxW-1:0] IDX_HEAD0 = 3'd0;
  localparam logic [IdxW-1:0] IDX_HEAD1 = 3'd1;
  localparam logic [IdxW-1:0] IDX_HEAD2 = 3'd2;
  localparam logic [IdxW-1:0] IDX_HEAD3 = 3'd3;
  localparam logic [IdxW-1:0] IDX_HEAD4 = 3'd4;

  localparam logic [ByteW-1:0] CheckBase = 8'hFF;

  localparam logic [ByteW-1:0] RstStartByte = 8'd141;
  localparam logic [ByteW-1:0] RstEndByte   = 8'd216;
  localparam logic [ByteW-1:0] RstEscByte   = 8'd171;
  localparam logic [ByteW-1:0] RstCodeEsc   = 8'd35;
  localparam logic [ByteW-1:0] RstCodeStart = 8'd5;
  localparam logic [ByteW-1:0] RstCodeEnd   = 8'd80;
  localparam logic [ByteW-1:0] RstFlags     = 8'd10;
  localparam logic [CapW-1:0]  RstCapacity  = 16'd65535;

  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] end_byte;
    logic [ByteW-1:0] esc_byte;
    logic [ByteW-1:0] code_esc;
    logic [ByteW-1:0] code_start;
    logic [ByteW-1:0] code_end;
    logic [ByteW-1:0] flags;
    logic [CapW-1:0]  capacity;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b2;
  } item_t;

endpackage

@@ sv/efe_cfg.sv @@
module efe_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [efe_pkg::ApbAddrW-1:0]  paddr,
  input  logic [efe_pkg::ApbDataW-1:0]  pwdata,
  output logic [efe_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output efe_pkg::cfg_t                 cfg_o
);
  import efe_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_START_BYTE: cfg_d.start_byte = pwdata[ByteW-1:0];
        REG_END_BYTE:   cfg_d.end_byte   = pwdata[ByteW-1:0];
        REG_ESC_BYTE:   cfg_d.esc_byte   = pwdata[ByteW-1:0];
        REG_CODE_ESC:   cfg_d.code_esc   = pwdata[ByteW-1:0];
        REG_CODE_START: cfg_d.code_start = pwdata[ByteW-1:0];
        REG_CODE_END:   cfg_d.code_end   = pwdata[ByteW-1:0];
        REG_FLAGS:      cfg_d.flags      = pwdata[ByteW-1:0];
        REG_CAPACITY:   cfg_d.capacity   = pwdata[CapW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_BYTE: prdata = ApbDataW'(cfg_q.start_byte);
      REG_END_BYTE:   prdata = ApbDataW'(cfg_q.end_byte);
      REG_ESC_BYTE:   prdata = ApbDataW'(cfg_q.esc_byte);
      REG_CODE_ESC:   prdata = ApbDataW'(cfg_q.code_esc);
      REG_CODE_START: prdata = ApbDataW'(cfg_q.code_start);
      REG_CODE_END:   prdata = ApbDataW'(cfg_q.code_end);
      REG_FLAGS:      prdata = ApbDataW'(cfg_q.flags);
      REG_CAPACITY:   prdata = ApbDataW'(cfg_q.capacity);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte <= RstStartByte;
      cfg_q.end_byte   <= RstEndByte;
      cfg_q.esc_byte   <= RstEscByte;
      cfg_q.code_esc   <= RstCodeEsc;
      cfg_q.code_start <= RstCodeStart;
      cfg_q.code_end   <= RstCodeEnd;
      cfg_q.flags      <= RstFlags;
      cfg_q.capacity   <= RstCapacity;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/efe_front.sv @@
module efe_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  efe_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [efe_pkg::KindW-1:0]  kind_i,
  input  logic [efe_pkg::ByteW-1:0]  device_id_i,
  input  logic [efe_pkg::ByteW-1:0]  command_id_i,
  input  logic [efe_pkg::ByteW-1:0]  sequence_req_i,
  input  logic [efe_pkg::ByteW-1:0]  payload_byte_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output efe_pkg::item_t             item_o
);
  import efe_pkg::*;

  logic             in_frame_q, in_frame_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic             take;
  logic             fwd;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    in_frame_d  = in_frame_q;
    sum_d       = sum_q;
    fwd         = 1'b0;
    item_o.kind = kind_i;
    item_o.b0   = payload_byte_i;
    item_o.b1   = command_id_i;
    item_o.b2   = sequence_req_i;
    case (kind_i)
      KIND_START: begin
        fwd        = 1'b1;
        in_frame_d = 1'b1;
        item_o.b0  = device_id_i;
        sum_d      = cfg_i.flags + device_id_i + command_id_i + sequence_req_i;
      end
      KIND_DATA: begin
        fwd   = in_frame_q;
        sum_d = sum_q + payload_byte_i;
      end
      KIND_END: begin
        fwd        = in_frame_q;
        in_frame_d = 1'b0;
        item_o.b0  = CheckBase - sum_q;
      end
      default: ;
    endcase
  end

  assign push_o = take && fwd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      sum_q      <= '0;
    end else if (take) begin
      in_frame_q <= in_frame_d;
      sum_q      <= sum_d;
    end
  end

endmodule

@@ sv/efe_queue.sv @@
module efe_queue #(
  parameter int unsigned Depth = efe_pkg::DefQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  efe_pkg::item_t                item_i,
  input  logic                          pop_i,
  output logic                          full_o,
  output logic                          valid_o,
  output efe_pkg::item_t                item_o,
  output logic [$clog2(Depth+1)-1:0]    count_o
);
  import efe_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ sv/efe_back.sv @@
module efe_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  efe_pkg::cfg_t              cfg_i,
  input  logic                       q_valid_i,
  input  efe_pkg::item_t             q_item_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [efe_pkg::ByteW-1:0]  wire_byte_o,
  output logic                       status_o,
  output logic                       frame_end_o,
  output logic                       run_last_o
);
  import efe_pkg::*;

  logic [IdxW-1:0]  idx_q, idx_d;
  logic             half_q, half_d;
  logic             alive_q, alive_d;
  logic [CapW-1:0]  bytes_q, bytes_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             out_status_q, out_status_d;
  logic             out_fend_q, out_fend_d;
  logic             out_last_q, out_last_d;

  logic             advance;
  logic [ByteW-1:0] elem_byte;
  logic             elem_raw, elem_fend, elem_last;
  logic             esc_hit;
  logic [ByteW-1:0] esc_code;
  logic [CapW-1:0]  bytes_cur;
  logic [CapW:0]    need1, need2;
  logic             fit1, fit2;
  logic             finish, fail;

  assign advance = !out_valid_q || out_ready_i;

  always_comb begin
    elem_byte = '0;
    elem_raw  = 1'b1;
    elem_fend = 1'b0;
    elem_last = 1'b1;
    case (q_item_i.kind)
      KIND_START: begin
        elem_raw  = 1'b0;
        elem_last = 1'b0;
        case (idx_q)
          IDX_HEAD0: begin
            elem_byte = cfg_i.start_byte;
            elem_raw  = 1'b1;
          end
          IDX_HEAD1: elem_byte = cfg_i.flags;
          IDX_HEAD2: elem_byte = q_item_i.b0;
          IDX_HEAD3: elem_byte = q_item_i.b1;
          default: begin
            elem_byte = q_item_i.b2;
            elem_last = 1'b1;
          end
        endcase
      end
      KIND_DATA: begin
        elem_byte = q_item_i.b0;
        elem_raw  = 1'b0;
      end
      KIND_END: begin
        if (idx_q == IDX_HEAD0) begin
          elem_byte = q_item_i.b0;
          elem_raw  = 1'b0;
          elem_last = 1'b0;
        end else begin
          elem_byte = cfg_i.end_byte;
          elem_fend = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    esc_hit  = 1'b1;
    esc_code = cfg_i.code_esc;
    if (elem_byte == cfg_i.esc_byte) begin
      esc_code = cfg_i.code_esc;
    end else if (elem_byte == cfg_i.start_byte) begin
      esc_code = cfg_i.code_start;
    end else if (elem_byte == cfg_i.end_byte) begin
      esc_code = cfg_i.code_end;
    end else begin
      esc_hit = 1'b0;
    end
  end

  assign bytes_cur = (q_item_i.kind == KIND_START && idx_q == IDX_HEAD0) ? '0 : bytes_q;
  assign need1     = {1'b0, bytes_cur} + (CapW+1)'(1);
  assign need2     = {1'b0, bytes_cur} + (CapW+1)'(2);
  assign fit1      = need1 <= {1'b0, cfg_i.capacity};
  assign fit2      = need2 <= {1'b0, cfg_i.capacity};

  always_comb begin
    pop_o        = 1'b0;
    idx_d        = idx_q;
    half_d       = half_q;
    alive_d      = alive_q;
    bytes_d      = bytes_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_byte_d   = out_byte_q;
    out_status_d = out_status_q;
    out_fend_d   = out_fend_q;
    out_last_d   = out_last_q;
    finish       = 1'b0;
    fail         = 1'b0;

    if (advance && q_valid_i) begin
      if (q_item_i.kind != KIND_START && !alive_q) begin
        pop_o = 1'b1;
        idx_d = '0;
      end else begin
        out_valid_d  = 1'b1;
        out_status_d = 1'b0;
        out_fend_d   = 1'b0;
        out_last_d   = 1'b0;
        if (q_item_i.kind == KIND_START) begin
          alive_d = 1'b1;
        end
        if (half_q) begin
          out_byte_d = esc_code;
          bytes_d    = bytes_cur + 1'b1;
          half_d     = 1'b0;
          finish     = 1'b1;
        end else if (!elem_raw && esc_hit) begin
          if (!fit2) begin
            fail = 1'b1;
          end else begin
            out_byte_d = cfg_i.esc_byte;
            bytes_d    = bytes_cur + 1'b1;
            half_d     = 1'b1;
          end
        end else if (!fit1) begin
          fail = 1'b1;
        end else begin
          out_byte_d = elem_byte;
          out_fend_d = elem_fend;
          bytes_d    = bytes_cur + 1'b1;
          finish     = 1'b1;
        end

        if (fail) begin
          out_byte_d   = '0;
          out_status_d = 1'b1;
          out_last_d   = 1'b1;
          alive_d      = 1'b0;
          half_d       = 1'b0;
          idx_d        = '0;
          pop_o        = 1'b1;
        end else if (finish) begin
          if (elem_last) begin
            out_last_d = 1'b1;
            idx_d      = '0;
            pop_o      = 1'b1;
            if (q_item_i.kind == KIND_END) begin
              alive_d = 1'b0;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      half_q      <= 1'b0;
      alive_q     <= 1'b0;
      bytes_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      half_q      <= half_d;
      alive_q     <= alive_d;
      bytes_q     <= bytes_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q   <= out_byte_d;
    out_status_q <= out_status_d;
    out_fend_q   <= out_fend_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign wire_byte_o = out_byte_q;
  assign status_o    = out_status_q;
  assign frame_end_o = out_fend_q;
  assign run_last_o  = out_last_q;

endmodule

@@ sv/escaped_frame_encoder_core.sv @@
// Escaped frame encoder. Start, data and end words enter on the slave stream;
// wire bytes leave on the master stream, one result word per byte, with tlast
// on the last byte that an input word causes. The front stage classifies each
// word and keeps the running checksum in the same cycle it is accepted, so
// input words are taken at one per cycle while the queue has room. The back
// stage sends one wire byte per cycle while the receiver is ready, from a
// registered output: a data word gives 1-2 bytes, an end word 2-3, a start
// word 5-9, an error result 1; words that cause no result leave the queue.
// The single byte sequencer thus sets throughput, one wire byte per clock
// with a ready receiver. Registers are written over APB and must only be
// changed while the encoder is idle. No clearing pass is needed after reset.
`include "escaped_frame_encoder_core_assert.svh"

module escaped_frame_encoder_core #(
  parameter int unsigned QueueDepth = efe_pkg::DefQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] device_id, [15:8] command_id, [23:16] sequence_req, [31:24] payload_byte
  input  logic [31:0]                   s_axis_tdata,
  // [1:0] kind
  input  logic [efe_pkg::KindW-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] wire_byte
  output logic [efe_pkg::ByteW-1:0]     m_axis_tdata,
  // [0] status, [1] frame_end
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [efe_pkg::ApbAddrW-1:0]  paddr,
  input  logic [efe_pkg::ApbDataW-1:0]  pwdata,
  output logic [efe_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import efe_pkg::*;

  cfg_t                         cfg;
  item_t                        push_item, head_item;
  logic                         push, pop, q_full, q_valid;
  logic [$clog2(QueueDepth+1)-1:0] q_count;
  logic                         status, frame_end;

  efe_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  efe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .kind_i         (s_axis_tuser),
    .device_id_i    (s_axis_tdata[7:0]),
    .command_id_i   (s_axis_tdata[15:8]),
    .sequence_req_i (s_axis_tdata[23:16]),
    .payload_byte_i (s_axis_tdata[31:24]),
    .q_full_i       (q_full),
    .push_o         (push),
    .item_o         (push_item)
  );

  efe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (head_item),
    .count_o (q_count)
  );

  efe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .wire_byte_o (m_axis_tdata),
    .status_o    (status),
    .frame_end_o (frame_end),
    .run_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = {frame_end, status};

  `EFE_ASSERT_IMPLIES(a_err_word, m_axis_tvalid && status, m_axis_tdata == '0 && m_axis_tlast && !frame_end)
  `EFE_ASSERT_IMPLIES(a_fend_byte, m_axis_tvalid && frame_end, m_axis_tdata == cfg.end_byte && m_axis_tlast)
  `EFE_ASSERT_IMPLIES(a_queue_bound, 1'b1, q_count <= ($clog2(QueueDepth+1))'(QueueDepth))
  `EFE_ASSERT_NEXT(a_full_no_ready, q_full, !s_axis_tready || !q_full)

endmodule

@@ tb/sv/escaped_frame_encoder_core_test.sv @@
`timescale 1ns / 100ps

module escaped_frame_encoder_core_test;
  import efe_pkg::*;

  localparam logic [KindW-1:0] KindIdle = 2'd3;
  localparam int QuietCycles = 40;
  localparam int CycleLimit  = 400000;
  localparam int DirRowsN    = 18;

  typedef struct packed {
    logic [ByteW-1:0] wbyte;
    logic             err;
    logic             fend;
    logic             last;
  } wire_res_t;

  typedef struct packed {
    logic [KindW-1:0]      kind;
    logic [ByteW-1:0]      dev;
    logic [ByteW-1:0]      cmd;
    logic [ByteW-1:0]      seq;
    logic [ByteW-1:0]      pay;
    logic                  typed;
    logic [2:0]            t_n;
    logic [0:4][ByteW-1:0] t_bytes;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // [7:0] device_id, [15:8] command_id, [23:16] sequence_req, [31:24] payload_byte
  logic [31:0]          s_axis_tdata;
  // [1:0] kind
  logic [KindW-1:0]     s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // [7:0] wire_byte
  logic [ByteW-1:0]     m_axis_tdata;
  // [0] status, [1] frame_end
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ApbAddrW-1:0]  paddr;
  logic [ApbDataW-1:0]  pwdata;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;

  escaped_frame_encoder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  cfg_t             cfg_model;
  logic             model_open;
  logic [ByteW-1:0] model_sum;
  logic [CapW-1:0]  model_count;

  wire_res_t wire_due [$];
  wire_res_t word_bytes [$];
  wire_res_t typed_bytes [$];
  bit        typed_on;
  wire_res_t seen;
  wire_res_t due;
  row_t      dir_rows [DirRowsN];

  int send_idle;
  int recv_stall;
  int mismatches;
  int cycles;
  int n_words;
  int n_results;
  int n_frames;
  int n_aborts;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d wire bytes outstanding", cycles, wire_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall);

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic void emit(logic [ByteW-1:0] b, logic err, logic fend);
    word_bytes.push_back('{b, err, fend, 1'b0});
  endfunction

  function automatic void close_frame();
    model_open  = 1'b0;
    model_sum   = '0;
    model_count = '0;
  endfunction

  function automatic bit put_raw(logic [ByteW-1:0] b, logic fend);
    if ({1'b0, model_count} + 17'd1 > {1'b0, cfg_model.capacity}) return 1'b0;
    emit(b, 1'b0, fend);
    model_count++;
    return 1'b1;
  endfunction

  function automatic bit put_body(logic [ByteW-1:0] v);
    logic [ByteW-1:0] code;
    if (v == cfg_model.esc_byte) code = cfg_model.code_esc;
    else if (v == cfg_model.start_byte) code = cfg_model.code_start;
    else if (v == cfg_model.end_byte) code = cfg_model.code_end;
    else return put_raw(v, 1'b0);
    if ({1'b0, model_count} + 17'd2 > {1'b0, cfg_model.capacity}) return 1'b0;
    emit(cfg_model.esc_byte, 1'b0, 1'b0);
    emit(code, 1'b0, 1'b0);
    model_count += 16'd2;
    return 1'b1;
  endfunction

  function automatic void encode_word(logic [KindW-1:0] kind, logic [31:0] data);
    logic [ByteW-1:0] head [4];
    logic [ByteW-1:0] chk;
    bit               ok;
    word_bytes.delete();
    ok = 1'b1;
    case (kind)
      KIND_START: begin
        close_frame();
        model_open = 1'b1;
        head[0] = cfg_model.flags;
        head[1] = data[7:0];
        head[2] = data[15:8];
        head[3] = data[23:16];
        for (int i = 0; i < 4; i++) model_sum += head[i];
        ok = put_raw(cfg_model.start_byte, 1'b0);
        for (int i = 0; ok && i < 4; i++) ok = put_body(head[i]);
      end
      KIND_DATA: begin
        if (!model_open) return;
        model_sum += data[31:24];
        ok = put_body(data[31:24]);
      end
      KIND_END: begin
        if (!model_open) return;
        chk = CheckBase - model_sum;
        ok = put_body(chk);
        if (ok) ok = put_raw(cfg_model.end_byte, 1'b1);
        if (ok) close_frame();
      end
      default: return;
    endcase
    if (!ok) begin
      emit('0, 1'b1, 1'b0);
      close_frame();
    end
    if (word_bytes.size() > 0) word_bytes[word_bytes.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [ApbDataW-1:0] reg_val(cfg_t c, logic [2:0] idx);
    case (idx)
      REG_START_BYTE: return ApbDataW'(c.start_byte);
      REG_END_BYTE:   return ApbDataW'(c.end_byte);
      REG_ESC_BYTE:   return ApbDataW'(c.esc_byte);
      REG_CODE_ESC:   return ApbDataW'(c.code_esc);
      REG_CODE_START: return ApbDataW'(c.code_start);
      REG_CODE_END:   return ApbDataW'(c.code_end);
      REG_FLAGS:      return ApbDataW'(c.flags);
      default:        return ApbDataW'(c.capacity);
    endcase
  endfunction

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(9))
      0:       return cfg_model.esc_byte;
      1:       return cfg_model.start_byte;
      2:       return cfg_model.end_byte;
      3:       return 8'h00;
      4:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic cfg_t rand_cfg(bit narrow, logic [CapW-1:0] cap);
    cfg_t c;
    logic [0:3][ByteW-1:0] pool;
    pool = {8'h00, 8'h01, 8'h02, 8'hFF};
    c.start_byte = narrow ? pool[$urandom_range(3)] : 8'($urandom);
    c.end_byte   = narrow ? pool[$urandom_range(3)] : 8'($urandom);
    c.esc_byte   = narrow ? pool[$urandom_range(3)] : 8'($urandom);
    c.code_esc   = 8'($urandom);
    c.code_start = 8'($urandom);
    c.code_end   = 8'($urandom);
    c.flags      = narrow ? pool[$urandom_range(3)] : 8'($urandom);
    c.capacity   = cap;
    return c;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = '{m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast};
      if (seen.err) n_aborts++;
      if (seen.fend) n_frames++;
      if (wire_due.size() == 0) begin
        flag_error($sformatf("unexpected word: byte %02h status %0b end %0b last %0b",
                             seen.wbyte, seen.err, seen.fend, seen.last));
      end else begin
        due = wire_due.pop_front();
        n_results++;
        if (seen !== due)
          flag_error($sformatf({"wire byte %0d: expected %02h/%0b/%0b/%0b,",
                                " got %02h/%0b/%0b/%0b (byte/status/end/last)"},
                               n_results, due.wbyte, due.err, due.fend, due.last,
                               seen.wbyte, seen.err, seen.fend, seen.last));
      end
    end
  end

  task automatic send_word(input logic [KindW-1:0] kind, input logic [31:0] data);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = data;
    s_axis_tuser  = kind;
    do @(posedge clk_i); while (!s_axis_tready);
    n_words++;
    encode_word(kind, data);
    if (typed_on) word_bytes = typed_bytes;
    foreach (word_bytes[i]) wire_due.push_back(word_bytes[i]);
    @(negedge clk_i);
  endtask

  task automatic apb_access(input logic [2:0] idx, input bit wr,
                            input logic [ApbDataW-1:0] wdata,
                            output logic [ApbDataW-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_regs();
    logic [ApbDataW-1:0] rd;
    for (int i = 0; i < 8; i++) begin
      apb_access(3'(i), 1'b0, '0, rd);
      if (rd !== reg_val(cfg_model, 3'(i)))
        flag_error($sformatf("register %0d: expected %0h, read %0h",
                             i, reg_val(cfg_model, 3'(i)), rd));
    end
  endtask

  task automatic wait_quiet();
    s_axis_tvalid = 1'b0;
    while (wire_due.size() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apply_cfg(input cfg_t c, input int sidle, input int rstall);
    logic [ApbDataW-1:0] rd;
    wait_quiet();
    for (int i = 0; i < 8; i++) apb_access(3'(i), 1'b1, reg_val(c, 3'(i)), rd);
    cfg_model  = c;
    check_regs();
    send_idle  = sidle;
    recv_stall = rstall;
  endtask

  task automatic run_frames(input int n_items);
    int          sent;
    int          nd;
    logic [31:0] d;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        send_word(2'($urandom_range(1, 3)), $urandom());
      end else begin
        d = $urandom();
        d[7:0]   = pick_byte();
        d[15:8]  = pick_byte();
        d[23:16] = pick_byte();
        send_word(KIND_START, d);
        sent++;
        nd = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(4);
        for (int j = 0; j < nd; j++) begin
          d = $urandom();
          d[31:24] = pick_byte();
          send_word(KIND_DATA, d);
          sent++;
        end
        if ($urandom_range(7) != 0) begin
          send_word(KIND_END, $urandom());
          sent++;
        end
      end
    end
  endtask

  initial begin
    row_t row;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle     = 0;
    recv_stall    = 0;
    mismatches    = 0;
    cycles        = 0;
    n_words       = 0;
    n_results     = 0;
    n_frames      = 0;
    n_aborts      = 0;
    typed_on      = 1'b0;
    cfg_model     = '{RstStartByte, RstEndByte, RstEscByte, RstCodeEsc, RstCodeStart,
                      RstCodeEnd, RstFlags, RstCapacity};
    close_frame();

    dir_rows = '{
      '{KIND_DATA,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 3'd0, 40'd0},
      '{KIND_END,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 3'd0, 40'd0},
      '{KindIdle,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 3'd0, 40'd0},
      '{KIND_START, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 3'd5,
        {8'd141, 8'd10, 8'd0, 8'd0, 8'd0}},
      '{KIND_DATA,  8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 3'd1, {8'd0, 32'd0}},
      '{KIND_DATA,  8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 3'd1, {8'd255, 32'd0}},
      '{KIND_END,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 3'd2, {8'd246, 8'd216, 24'd0}},
      '{KIND_START, 8'd171, 8'd141, 8'd216, 8'h00, 1'b0, 3'd0, 40'd0},
      '{KIND_DATA,  8'h00, 8'h00, 8'h00, 8'd171, 1'b0, 3'd0, 40'd0},
      '{KIND_DATA,  8'h00, 8'h00, 8'h00, 8'd141, 1'b0, 3'd0, 40'd0},
      '{KIND_DATA,  8'h00, 8'h00, 8'h00, 8'd216, 1'b0, 3'd0, 40'd0},
      '{KIND_END,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 3'd0, 40'd0},
      '{KIND_START, 8'd74, 8'h00, 8'h00, 8'h00, 1'b1, 3'd5,
        {8'd141, 8'd10, 8'd74, 8'd0, 8'd0}},
      '{KIND_END,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 3'd3,
        {8'd171, 8'd35, 8'd216, 16'd0}},
      '{KIND_START, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0, 3'd0, 40'd0},
      '{KIND_DATA,  8'h00, 8'h00, 8'h00, 8'h5A, 1'b0, 3'd0, 40'd0},
      '{KIND_START, 8'h01, 8'h02, 8'h03, 8'h00, 1'b1, 3'd5,
        {8'd141, 8'd10, 8'd1, 8'd2, 8'd3}},
      '{KIND_DATA,  8'h00, 8'h00, 8'h00, 8'h11, 1'b0, 3'd0, 40'd0}
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    check_regs();

    for (int r = 0; r < DirRowsN; r++) begin
      row = dir_rows[r];
      typed_bytes.delete();
      typed_on = row.typed;
      for (int i = 0; i < row.t_n; i++)
        typed_bytes.push_back('{row.t_bytes[i], 1'b0,
                                (row.kind == KIND_END) && (i == row.t_n - 1),
                                i == row.t_n - 1});
      send_word(row.kind, {row.pay, row.seq, row.cmd, row.dev});
    end
    typed_on = 1'b0;

    // lower capacity under the open frame, then force an escaped pair past it
    apply_cfg('{RstStartByte, RstEndByte, RstEscByte, RstCodeEsc, RstCodeStart,
                RstCodeEnd, RstFlags, 16'd7}, 78, 0);
    send_word(KIND_DATA, {cfg_model.esc_byte, 24'hFFFFFF});
    run_frames(20);

    apply_cfg('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'hFF, 16'h0000}, 0, 78);
    run_frames(10);

    apply_cfg('{8'h7E, 8'h7E, 8'h7D, 8'h5E, 8'h5D, 8'h5C, 8'h7D, 16'hFFFF}, 29, 29);
    run_frames(25);

    apply_cfg(rand_cfg(1'b0, 16'($urandom_range(6, 24))), 0, 0);
    run_frames(25);

    apply_cfg(rand_cfg(1'b1, 16'hFFFF), 29, 29);
    run_frames(20);

    wait_quiet();
    $display("%0d words taken, %0d wire bytes checked, %0d frames closed, %0d aborts",
             n_words, n_results, n_frames, n_aborts);
    $display("six register settings, idling: none, sender, receiver, both; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ escaped_frame_encoder_core.f @@
+incdir+sv
sv/efe_pkg.sv
sv/efe_cfg.sv
sv/efe_front.sv
sv/efe_queue.sv
sv/efe_back.sv
sv/escaped_frame_encoder_core.sv
tb/sv/escaped_frame_encoder_core_test.sv
